@@ hw/rtl/lrcp_pkg.sv @@
// Package for the loop range chunk partitioner: payload types, register
// indexes, divider sizing and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrcp_pkg;

	localparam int MAX_WORKERS = 64;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ITER_W = 32;
	localparam int STRIDE_W = 31;
	localparam int WORKER_CNT_W = 7;
	localparam int TASKS_W = 16;
	localparam int COUNT_W = 32;
	localparam int WORKER_IDX_W = 6;
	localparam int SLOT_W = 31;

	localparam int DVD_W = 33;
	localparam int DVS_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_START  = 3'd0,
		CFG_RANGE_STOP   = 3'd1,
		CFG_STRIDE       = 3'd2,
		CFG_WORKER_COUNT = 3'd3,
		CFG_CHUNK_TASKS  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_TASKS   = 2'd0,
		DIV_CHUNKS  = 2'd1,
		DIV_WORKERS = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic restart;
	} req_t;

	typedef struct packed {
		logic                     valid_res;
		logic [WORKER_IDX_W-1:0]  worker_index;
		logic [SLOT_W-1:0]        slot_in_worker;
		logic signed [ITER_W-1:0] chunk_begin;
		logic signed [ITER_W-1:0] chunk_end;
		logic                     last_of_worker;
		logic                     last_of_job;
	} res_t;

	typedef struct packed {
		logic     init_walk;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_latch;
		logic     step_en;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lrcp_chan_if.sv @@
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter; used with lrcp_pkg::req_t and lrcp_pkg::res_t.
`timescale 1ns / 1ps
`default_nettype none

interface lrcp_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lrcp_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
// Depends on lrcp_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module lrcp_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [lrcp_pkg::DVD_W-1:0]   dividend,
	input  wire logic [lrcp_pkg::DVS_W-1:0]   divisor,
	output logic                              busy,
	output logic                              done,
	output logic [lrcp_pkg::DVD_W-1:0]        quotient,
	output logic [lrcp_pkg::DVS_W-1:0]        remainder
);
	localparam int DVD_W = lrcp_pkg::DVD_W;
	localparam int DVS_W = lrcp_pkg::DVS_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff = trial - {1'b0, dvs_q};
		fits = (trial >= {1'b0, dvs_q});
		quotient = {quo_q[DVD_W-2:0], fits};
		remainder = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == CNT_W'(DVD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quotient;
			rem_q <= remainder;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lrcp_ctrl.sv @@
// Control FSM: takes request beats, sequences the three partition divisions
// on restart, then the step product and the result beat. Depends on lrcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrcp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_restart,
	output logic                   req_ready,
	input  wire lrcp_pkg::status_t status,
	output lrcp_pkg::cmd_t         cmd
);
	typedef enum logic [5:0] {
		S_IDLE        = 6'b000001,
		S_DIV_TASKS   = 6'b000010,
		S_DIV_CHUNKS  = 6'b000100,
		S_DIV_WORKERS = 6'b001000,
		S_STEP        = 6'b010000,
		S_EMIT        = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = lrcp_pkg::DIV_TASKS;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_restart) begin
						cmd.init_walk = 1'b1;
						state_d = S_DIV_TASKS;
					end else begin
						state_d = S_STEP;
					end
				end
			end
			S_DIV_TASKS: begin
				cmd.div_sel = lrcp_pkg::DIV_TASKS;
				cmd.div_start = !status.div_busy;
				cmd.div_latch = status.div_done;
				if (status.div_done) begin
					state_d = S_DIV_CHUNKS;
				end
			end
			S_DIV_CHUNKS: begin
				cmd.div_sel = lrcp_pkg::DIV_CHUNKS;
				cmd.div_start = !status.div_busy;
				cmd.div_latch = status.div_done;
				if (status.div_done) begin
					state_d = S_DIV_WORKERS;
				end
			end
			S_DIV_WORKERS: begin
				cmd.div_sel = lrcp_pkg::DIV_WORKERS;
				cmd.div_start = !status.div_busy;
				cmd.div_latch = status.div_done;
				if (status.div_done) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step_en = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lrcp_dp.sv @@
// Datapath: configuration registers, partition counts, walk counters,
// step product and the result register. Uses lrcp_div and lrcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrcp_dp #(
	parameter int MAX_WORKERS = lrcp_pkg::MAX_WORKERS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lrcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lrcp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire lrcp_pkg::cmd_t                    cmd,
	output lrcp_pkg::status_t                      status,
	input  wire logic                              res_ready,
	output logic                                   res_valid,
	output lrcp_pkg::res_t                         res_data
);
	localparam int ITER_W = lrcp_pkg::ITER_W;
	localparam int STRIDE_W = lrcp_pkg::STRIDE_W;
	localparam int WC_W = lrcp_pkg::WORKER_CNT_W;
	localparam int TASKS_W = lrcp_pkg::TASKS_W;
	localparam int COUNT_W = lrcp_pkg::COUNT_W;
	localparam int DVD_W = lrcp_pkg::DVD_W;
	localparam int DVS_W = lrcp_pkg::DVS_W;
	localparam int WI_W = lrcp_pkg::WORKER_IDX_W;
	localparam int SLOT_W = lrcp_pkg::SLOT_W;

	logic [ITER_W-1:0]   range_start_q;
	logic [ITER_W-1:0]   range_stop_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [WC_W-1:0]     worker_count_q;
	logic [TASKS_W-1:0]  chunk_tasks_q;

	logic [COUNT_W-1:0]  tasks_q;
	logic [COUNT_W-1:0]  chunks_total_q;
	logic [COUNT_W-1:0]  base_q;
	logic [WC_W-1:0]     extra_q;
	logic [WC_W-1:0]     cur_worker_q;
	logic [COUNT_W-1:0]  cur_slot_q;
	logic [COUNT_W-1:0]  handed_q;
	logic [ITER_W-1:0]   next_iter_q;
	logic [ITER_W-1:0]   step_q;
	logic                res_valid_q;
	lrcp_pkg::res_t      res_q;

	logic [STRIDE_W-1:0] stride_eff;
	logic [TASKS_W-1:0]  tasks_eff;
	logic [WC_W-1:0]     workers_eff;
	logic [ITER_W:0]     span;
	logic                span_pos;
	logic [DVD_W-1:0]    dividend;
	logic [DVS_W-1:0]    divisor;
	logic                div_busy;
	logic                div_done;
	logic [DVD_W-1:0]    div_quo;
	logic [DVS_W-1:0]    div_rem;

	logic                avail;
	logic [COUNT_W:0]    run_len;
	logic                last_w;
	logic                last_j;
	logic [ITER_W-1:0]   chunk_end;
	logic [TASKS_W+STRIDE_W-1:0] product;
	lrcp_pkg::res_t      res_d;

	always_comb begin
		stride_eff = (stride_q == '0) ? STRIDE_W'(1) : stride_q;
		tasks_eff = (chunk_tasks_q == '0) ? TASKS_W'(1) : chunk_tasks_q;
		if (worker_count_q == '0) begin
			workers_eff = WC_W'(1);
		end else if (32'(worker_count_q) > 32'(MAX_WORKERS)) begin
			workers_eff = WC_W'(MAX_WORKERS);
		end else begin
			workers_eff = worker_count_q;
		end

		span = {range_stop_q[ITER_W-1], range_stop_q} - {range_start_q[ITER_W-1], range_start_q};
		span_pos = !span[ITER_W] && (span != '0);

		unique case (cmd.div_sel)
			lrcp_pkg::DIV_TASKS: begin
				dividend = span_pos ? (span + DVD_W'(stride_eff) - DVD_W'(1)) : '0;
				divisor = stride_eff;
			end
			lrcp_pkg::DIV_CHUNKS: begin
				dividend = DVD_W'(tasks_q) + DVD_W'(tasks_eff) - DVD_W'(1);
				divisor = DVS_W'(tasks_eff);
			end
			lrcp_pkg::DIV_WORKERS: begin
				dividend = DVD_W'(chunks_total_q);
				divisor = DVS_W'(workers_eff);
			end
			default: begin
				dividend = '0;
				divisor = DVS_W'(1);
			end
		endcase
	end

	lrcp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign product = tasks_eff * stride_eff;

	always_comb begin
		avail = (handed_q < chunks_total_q);
		run_len = {1'b0, base_q} + ((cur_worker_q < extra_q) ? (COUNT_W+1)'(1) : '0);
		last_w = (({1'b0, cur_slot_q} + (COUNT_W+1)'(1)) >= run_len);
		last_j = (({1'b0, handed_q} + (COUNT_W+1)'(1)) == {1'b0, chunks_total_q});
		chunk_end = last_j ? range_stop_q : (next_iter_q + step_q);

		res_d = '0;
		if (avail) begin
			res_d.valid_res = 1'b1;
			res_d.worker_index = cur_worker_q[WI_W-1:0];
			res_d.slot_in_worker = cur_slot_q[SLOT_W-1:0];
			res_d.chunk_begin = next_iter_q;
			res_d.chunk_end = chunk_end;
			res_d.last_of_worker = last_w;
			res_d.last_of_job = last_j;
		end
	end

	assign status.div_busy = div_busy;
	assign status.div_done = div_done;
	assign status.out_free = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q <= '0;
			range_stop_q <= '0;
			stride_q <= STRIDE_W'(1);
			worker_count_q <= WC_W'(1);
			chunk_tasks_q <= TASKS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrcp_pkg::CFG_RANGE_START:  range_start_q <= cfg_data[ITER_W-1:0];
				lrcp_pkg::CFG_RANGE_STOP:   range_stop_q <= cfg_data[ITER_W-1:0];
				lrcp_pkg::CFG_STRIDE:       stride_q <= cfg_data[STRIDE_W-1:0];
				lrcp_pkg::CFG_WORKER_COUNT: worker_count_q <= cfg_data[WC_W-1:0];
				lrcp_pkg::CFG_CHUNK_TASKS:  chunk_tasks_q <= cfg_data[TASKS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasks_q <= '0;
			chunks_total_q <= '0;
			base_q <= '0;
			extra_q <= '0;
			cur_worker_q <= '0;
			cur_slot_q <= '0;
			handed_q <= '0;
			next_iter_q <= '0;
		end else begin
			if (cmd.init_walk) begin
				cur_worker_q <= '0;
				cur_slot_q <= '0;
				handed_q <= '0;
				next_iter_q <= range_start_q;
			end else if (cmd.emit && avail) begin
				handed_q <= handed_q + COUNT_W'(1);
				if (!last_j) begin
					next_iter_q <= chunk_end;
					if (last_w) begin
						cur_worker_q <= cur_worker_q + WC_W'(1);
						cur_slot_q <= '0;
					end else begin
						cur_slot_q <= cur_slot_q + COUNT_W'(1);
					end
				end
			end
			if (cmd.div_latch) begin
				unique case (cmd.div_sel)
					lrcp_pkg::DIV_TASKS:  tasks_q <= div_quo[COUNT_W-1:0];
					lrcp_pkg::DIV_CHUNKS: chunks_total_q <= div_quo[COUNT_W-1:0];
					lrcp_pkg::DIV_WORKERS: begin
						base_q <= div_quo[COUNT_W-1:0];
						extra_q <= div_rem[WC_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_en) begin
			step_q <= product[ITER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/loop_range_chunk_partitioner.sv @@
// Loop range chunk partitioner, top level.
// Depends on lrcp_pkg, lrcp_chan_if, lrcp_ctrl, lrcp_dp (with lrcp_div).
//
// Usage: program range_start, range_stop, stride, worker_count and
// chunk_tasks through cfg_we/cfg_index/cfg_data (indexes 0 to 4) while the
// block is idle. Each beat on req asks for one chunk; restart = 1 recomputes
// the partition first. Every req beat yields exactly one res beat: a chunk
// descriptor, or valid_res = 0 with all fields zero once the job is done.
// A plain request goes through the step and emit states to the result
// register; a restart first runs three serial divisions (one quotient bit per
// cycle in the shared divider). One request is in flight at a time: the next
// request is taken only once the block is back in idle.
// The result sits in an output register: a new request is accepted while it
// waits, and the block holds in its final step until res.ready frees that
// register. Reset (arst_n low) sets stride, worker_count and chunk_tasks to
// 1, the range to zero and the job to empty.
`timescale 1ns / 1ps
`default_nettype none

module loop_range_chunk_partitioner #(
	parameter int MAX_WORKERS = lrcp_pkg::MAX_WORKERS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lrcp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lrcp_pkg::CFG_DATA_W-1:0] cfg_data,
	lrcp_chan_if.sink                            req,
	lrcp_chan_if.source                          res
);
	lrcp_pkg::cmd_t    cmd;
	lrcp_pkg::status_t status;
	lrcp_pkg::req_t    req_beat;
	logic              req_ready;
	logic              res_valid;
	lrcp_pkg::res_t    res_beat;

	assign req_beat = req.data;
	assign req.ready = req_ready;
	assign res.valid = res_valid;
	assign res.data = res_beat;

	lrcp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_restart (req_beat.restart),
		.req_ready   (req_ready),
		.status      (status),
		.cmd         (cmd)
	);

	lrcp_dp #(
		.MAX_WORKERS (MAX_WORKERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.res_ready (res.ready),
		.res_valid (res_valid),
		.res_data  (res_beat)
	);

endmodule

`default_nettype wire

@@ verif/loop_range_chunk_partitioner_test.sv @@
// Self-checking testbench for loop_range_chunk_partitioner: a directed table of
// register writes and chunk requests, then randomized partition walks.
// Depends on lrcp_pkg, lrcp_chan_if and the RTL of the block.
`timescale 1ns / 1ps

module loop_range_chunk_partitioner_test;
	import lrcp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 850;
	localparam int SETTLE_CYCLES = 120;
	localparam int RESET_CYCLES = 11;
	localparam int MAX_IDLE = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
	localparam int SPARE_COUNT = 3;
	localparam longint ITER_SPAN = 64'h1_0000_0000;

	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		bit                    restart;
		bit                    typed;
		res_t                  want;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lrcp_chan_if #(.payload_t(req_t)) req_ch ();
	lrcp_chan_if #(.payload_t(res_t)) res_ch ();

	loop_range_chunk_partitioner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.res(res_ch)
	);

	// register copies
	logic signed [ITER_W-1:0]   reg_start;
	logic signed [ITER_W-1:0]   reg_stop;
	logic [STRIDE_W-1:0]        reg_stride;
	logic [WORKER_CNT_W-1:0]    reg_workers;
	logic [TASKS_W-1:0]         reg_tasks;

	// partition walk
	longint unsigned chunk_count;
	longint unsigned base_run;
	longint unsigned extra_runs;
	longint unsigned cur_worker;
	longint unsigned cur_slot;
	longint unsigned handed;
	longint          next_begin;

	res_t        chunks_due[$];
	script_row_t script[$];
	int          sent;
	int          mismatches;
	int          cycles = 0;
	bit          src_idle;
	bit          sink_idle;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic res_t next_chunk(input bit rs);
		longint s, ct, w, span, tasks, fin;
		longint unsigned run;
		bit end_w, end_j;
		res_t r;
		r = '0;
		s = (reg_stride == 0) ? 1 : longint'(reg_stride);
		ct = (reg_tasks == 0) ? 1 : longint'(reg_tasks);
		if (rs) begin
			if (reg_workers == 0)
				w = 1;
			else if (reg_workers > MAX_WORKERS)
				w = MAX_WORKERS;
			else
				w = reg_workers;
			span = longint'(reg_stop) - longint'(reg_start);
			tasks = (span > 0) ? (span + s - 1) / s : 0;
			chunk_count = (tasks + ct - 1) / ct;
			base_run = chunk_count / w;
			extra_runs = chunk_count % w;
			cur_worker = 0;
			cur_slot = 0;
			handed = 0;
			next_begin = longint'(reg_start);
		end
		if (handed >= chunk_count)
			return r;
		run = base_run + ((cur_worker < extra_runs) ? 1 : 0);
		end_w = (cur_slot + 1 >= run);
		end_j = (handed + 1 == chunk_count);
		fin = end_j ? longint'(reg_stop) : next_begin + ct * s;
		r.valid_res = 1'b1;
		r.worker_index = cur_worker[WORKER_IDX_W-1:0];
		r.slot_in_worker = cur_slot[SLOT_W-1:0];
		r.chunk_begin = next_begin[ITER_W-1:0];
		r.chunk_end = fin[ITER_W-1:0];
		r.last_of_worker = end_w;
		r.last_of_job = end_j;
		handed++;
		if (!end_j) begin
			next_begin = fin;
			if (end_w) begin
				cur_worker++;
				cur_slot = 0;
			end else begin
				cur_slot++;
			end
		end
		return r;
	endfunction

	function automatic res_t chunk_of(input int wk, input int slot, input logic [31:0] b,
			input logic [31:0] e, input bit lw, input bit lj);
		res_t r;
		r.valid_res = 1'b1;
		r.worker_index = WORKER_IDX_W'(wk);
		r.slot_in_worker = SLOT_W'(slot);
		r.chunk_begin = b;
		r.chunk_end = e;
		r.last_of_worker = lw;
		r.last_of_job = lj;
		return r;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		script_row_t row;
		row = '{1'b1, idx, data, 1'b0, 1'b0, '0};
		script.push_back(row);
	endfunction

	function automatic void add_req(input bit rs, input bit typed = 1'b0, input res_t want = '0);
		script_row_t row;
		row = '{1'b0, '0, '0, rs, typed, want};
		script.push_back(row);
	endfunction

	function automatic void plan_directed();
		// nothing handed out before the first restart, and the reset range is empty
		add_req(1'b0, 1'b1, '0);
		add_req(1'b1, 1'b1, '0);
		// widest range, largest stride: three chunks over 64 workers
		add_write(CFG_RANGE_START, 32'h8000_0000);
		add_write(CFG_RANGE_STOP, 32'h7FFF_FFFF);
		add_write(CFG_STRIDE, 32'h7FFF_FFFF);
		add_write(CFG_WORKER_COUNT, 32'd64);
		add_write(CFG_CHUNK_TASKS, 32'd1);
		add_req(1'b1, 1'b1, chunk_of(0, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0));
		add_req(1'b0, 1'b1, chunk_of(1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 1'b1, 1'b0));
		add_req(1'b0, 1'b1, chunk_of(2, 0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b1, 1'b1));
		add_req(1'b0, 1'b1, '0);
		// zero workers, zero chunk size and zero stride all act as one
		add_write(CFG_WORKER_COUNT, 32'hFFFF_FF80);
		add_write(CFG_CHUNK_TASKS, 32'hFFFF_0000);
		add_write(CFG_STRIDE, 32'h8000_0000);
		add_write(CFG_RANGE_START, 32'd0);
		add_write(CFG_RANGE_STOP, 32'd3);
		add_req(1'b1);
		add_req(1'b0);
		add_req(1'b0);
		add_req(1'b0, 1'b1, '0);
		// worker count above the maximum, largest chunk
		add_write(CFG_WORKER_COUNT, 32'h0000_007F);
		add_write(CFG_CHUNK_TASKS, 32'hFFFF_FFFF);
		add_write(CFG_RANGE_STOP, 32'd5);
		add_req(1'b1, 1'b1, chunk_of(0, 0, 32'd0, 32'd5, 1'b1, 1'b1));
		add_req(1'b0, 1'b1, '0);
		// writes past the register list change nothing
		for (int k = 0; k < SPARE_COUNT; k++)
			add_write(CFG_SPARE_FIRST + CFG_IDX_W'(k), 32'hFFFF_FFFF);
		add_req(1'b1, 1'b1, chunk_of(0, 0, 32'd0, 32'd5, 1'b1, 1'b1));
		// reversed, equal and most negative ranges
		add_write(CFG_RANGE_START, 32'd10);
		add_write(CFG_RANGE_STOP, 32'hFFFF_FFF6);
		add_req(1'b1, 1'b1, '0);
		add_write(CFG_RANGE_START, 32'hFFFF_FFF6);
		add_req(1'b1, 1'b1, '0);
		add_write(CFG_RANGE_START, 32'h7FFF_FFFF);
		add_write(CFG_RANGE_STOP, 32'h8000_0000);
		add_req(1'b1, 1'b1, '0);
		add_req(1'b0, 1'b1, '0);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_RANGE_START:  reg_start = data;
			CFG_RANGE_STOP:   reg_stop = data;
			CFG_STRIDE:       reg_stride = data[STRIDE_W-1:0];
			CFG_WORKER_COUNT: reg_workers = data[WORKER_CNT_W-1:0];
			CFG_CHUNK_TASKS:  reg_tasks = data[TASKS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (chunks_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_req(input bit rs, input bit typed = 1'b0, input res_t want = '0);
		int gap;
		res_t got;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data.restart <= rs;
		do @(posedge clk); while (!req_ch.ready);
		got = next_chunk(rs);
		chunks_due.push_back(typed ? want : got);
		sent++;
	endtask

	task automatic random_phase();
		int kind, w_eff, n_chunks, n_req, ct_eff;
		longint s_eff, tasks, span, start_at, stop_at;
		logic [31:0] wv, sv, cv, a, b;
		bit live_edit;
		kind = $urandom_range(0, 9);
		src_idle = ($urandom_range(0, 3) != 0);
		sink_idle = ($urandom_range(0, 3) != 0);
		live_edit = ($urandom_range(0, 4) == 0);
		drain();

		case ($urandom_range(0, 7))
			0: wv = 0;
			1: wv = $urandom_range(MAX_WORKERS + 1, 127);
			2: wv = 1;
			3: wv = MAX_WORKERS;
			default: wv = $urandom_range(1, MAX_WORKERS);
		endcase
		w_eff = (wv == 0) ? 1 : ((wv > MAX_WORKERS) ? MAX_WORKERS : wv);
		case ($urandom_range(0, 5))
			0: cv = 0;
			1: cv = $urandom_range(1000, 65535);
			2: cv = 65535;
			default: cv = $urandom_range(1, 8);
		endcase
		ct_eff = (cv == 0) ? 1 : cv;
		case ($urandom_range(0, 5))
			0: sv = 0;
			1: sv = 32'h7FFF_FFFF;
			2: sv = $urandom_range(1, 32'h7FFF_FFFF);
			default: sv = $urandom_range(1, 9);
		endcase
		s_eff = (sv == 0) ? 1 : sv;
		if (longint'(ct_eff) * s_eff * (2 * w_eff + 3) >= ITER_SPAN) begin
			sv = $urandom_range(1, 4);
			s_eff = sv;
		end
		n_chunks = $urandom_range(1, 2 * w_eff + 3);
		tasks = longint'(n_chunks - 1) * ct_eff + $urandom_range(1, ct_eff);
		span = (tasks - 1) * s_eff + $urandom_range(1, s_eff);
		start_at = -longint'(ITER_SPAN / 2) + longint'($urandom_range(0, ITER_SPAN - 1 - span));
		stop_at = start_at + span;

		if (kind == 7) begin
			// empty or reversed range
			a = $urandom;
			b = ($urandom_range(0, 3) == 0) ? a : $urandom;
			start_at = ($signed(a) > $signed(b)) ? longint'($signed(a)) : longint'($signed(b));
			stop_at = ($signed(a) > $signed(b)) ? longint'($signed(b)) : longint'($signed(a));
			n_chunks = 0;
		end else if (kind == 8) begin
			start_at = longint'($signed($urandom));
			stop_at = longint'($signed($urandom));
			sv = $urandom;
			wv = $urandom;
			cv = $urandom;
		end

		a = $urandom;
		write_reg(CFG_RANGE_START, start_at[31:0]);
		write_reg(CFG_RANGE_STOP, stop_at[31:0]);
		write_reg(CFG_STRIDE, {a[31], sv[30:0]});
		write_reg(CFG_WORKER_COUNT, {a[31:7], wv[6:0]});
		write_reg(CFG_CHUNK_TASKS, {a[31:16], cv[15:0]});
		if (kind == 9)
			for (int k = 0; k < SPARE_COUNT; k++)
				write_reg(CFG_SPARE_FIRST + CFG_IDX_W'(k), $urandom);
		end_writes();

		if (kind == 8) begin
			n_req = $urandom_range(1, 20);
			send_req(1'b1);
			for (int i = 0; i < n_req; i++)
				send_req($urandom_range(0, 3) == 0);
		end else begin
			n_req = n_chunks + $urandom_range(0, 2);
			send_req(1'b1);
			for (int i = 1; i <= n_req; i++) begin
				if (live_edit && i == n_chunks / 2 + 1) begin
					// stride, chunk size and stop are read live mid walk
					drain();
					write_reg(CFG_RANGE_STOP, $urandom);
					write_reg(CFG_STRIDE,
						{1'($urandom_range(0, 1)), 28'd0, 3'($urandom_range(0, 4))});
					write_reg(CFG_CHUNK_TASKS, {16'($urandom), 16'($urandom_range(0, 8))});
					end_writes();
				end
				send_req($urandom_range(0, 29) == 0);
			end
		end
	endtask

	function automatic void check_chunk(input res_t seen);
		res_t want;
		if (chunks_due.size() == 0) begin
			$error("result beat with nothing expected");
			mismatches++;
			return;
		end
		want = chunks_due.pop_front();
		if (seen.valid_res !== want.valid_res) begin
			$error("valid_res: expected %0d, got %0d", want.valid_res, seen.valid_res);
			mismatches++;
		end
		if (seen.worker_index !== want.worker_index) begin
			$error("worker_index: expected %0d, got %0d", want.worker_index, seen.worker_index);
			mismatches++;
		end
		if (seen.slot_in_worker !== want.slot_in_worker) begin
			$error("slot_in_worker: expected %0d, got %0d",
				want.slot_in_worker, seen.slot_in_worker);
			mismatches++;
		end
		if (seen.chunk_begin !== want.chunk_begin) begin
			$error("chunk_begin: expected %0d, got %0d", want.chunk_begin, seen.chunk_begin);
			mismatches++;
		end
		if (seen.chunk_end !== want.chunk_end) begin
			$error("chunk_end: expected %0d, got %0d", want.chunk_end, seen.chunk_end);
			mismatches++;
		end
		if (seen.last_of_worker !== want.last_of_worker) begin
			$error("last_of_worker: expected %0d, got %0d",
				want.last_of_worker, seen.last_of_worker);
			mismatches++;
		end
		if (seen.last_of_job !== want.last_of_job) begin
			$error("last_of_job: expected %0d, got %0d", want.last_of_job, seen.last_of_job);
			mismatches++;
		end
	endfunction

	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			check_chunk(res_ch.data);
		end
	end

	initial begin : stimulus
		script_row_t row;
		bit in_writes;
		int directed_sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		sent = 0;
		mismatches = 0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		reg_start = '0;
		reg_stop = '0;
		reg_stride = 1;
		reg_workers = 1;
		reg_tasks = 1;
		chunk_count = 0;
		base_run = 0;
		extra_runs = 0;
		cur_worker = 0;
		cur_slot = 0;
		handed = 0;
		next_begin = 0;
		in_writes = 1'b0;
		plan_directed();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			row = script[i];
			if (row.is_write) begin
				if (!in_writes)
					drain();
				in_writes = 1'b1;
				write_reg(row.idx, row.data);
			end else begin
				if (in_writes)
					end_writes();
				in_writes = 1'b0;
				send_req(row.restart, row.typed, row.want);
			end
		end
		directed_sent = sent;

		while (sent < directed_sent + RANDOM_ITEMS)
			random_phase();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/lrcp_pkg.sv
hw/rtl/lrcp_chan_if.sv
hw/rtl/lrcp_div.sv
hw/rtl/lrcp_ctrl.sv
hw/rtl/lrcp_dp.sv
hw/rtl/loop_range_chunk_partitioner.sv
verif/loop_range_chunk_partitioner_test.sv
